// File: rtl/bvmc_pkg.sv
package bvmc_pkg;

    // Bus function codes
    typedef enum logic [3:0] {
        FN_DIRECT_RD = 4'd0,
        FN_DIRECT_WR = 4'd1,
        FN_LATCH_RD  = 4'd2,
        FN_LATCH_WR  = 4'd3,
        FN_LATCH_HI  = 4'd4,
        FN_LATCH_LO  = 4'd5,
        FN_PAL_WR    = 4'd6,
        FN_BANK      = 4'd7,
        FN_PIXEL     = 4'd8
    } t_func;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    // APB register map
    localparam int          CFG_ADDR_W     = 3;
    localparam logic        REG_WRITE_MASK = 1'b0;
    localparam logic [7:0]  MASK_RESET     = 8'hFF;

    // 2 color bits over 2 shared intensity bits
    function automatic logic [7:0] level(input logic [3:0] idx);
        logic [7:0] v;
        case (idx)
            4'd0:    v = 8'h00;
            4'd1:    v = 8'h12;
            4'd2:    v = 8'h24;
            4'd3:    v = 8'h49;
            4'd4:    v = 8'h12;
            4'd5:    v = 8'h24;
            4'd6:    v = 8'h49;
            4'd7:    v = 8'h92;
            4'd8:    v = 8'h5b;
            4'd9:    v = 8'h6d;
            4'd10:   v = 8'h92;
            4'd11:   v = 8'hdb;
            4'd12:   v = 8'h7f;
            4'd13:   v = 8'h91;
            4'd14:   v = 8'hb6;
            default: v = 8'hff;
        endcase
        return v;
    endfunction

    function automatic t_rgb expand_color(input logic [7:0] v);
        t_rgb c;
        c.red   = level({v[7:6], v[1:0]});
        c.green = level({v[5:4], v[1:0]});
        c.blue  = level({v[3:2], v[1:0]});
        return c;
    endfunction

endpackage

// File: rtl/bitmap_video_memory_controller.sv
// Pipeline: a transaction accepted at one clock edge passes the stage 1, stage 2 and
//   output registers before its result shows with o_valid high.
// Throughput: one transaction per cycle; the receiver cannot stall, so busy only
//   reflects reset. Rate is set by the single read port of each RAM.
// Reset: synchronous, active low. busy is high during reset and until r_run sets after
//   it; latches, bank and pipeline valids clear; the write mask goes to all ones. RAMs are not cleared.
module bitmap_video_memory_controller
    import bvmc_pkg::*;
#(
    parameter int VIDEO_DEPTH   = 65536,
    parameter int PALETTE_BANKS = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // command channel
    input  logic                  start,
    output logic                  busy,
    input  logic [3:0]            i_func,
    input  logic [15:0]           i_offset,
    input  logic [7:0]            i_data,
    // result channel
    output logic                  o_valid,
    output logic [7:0]            o_read_data,
    output logic [9:0]            o_pen_index,
    output logic [7:0]            o_red,
    output logic [7:0]            o_green,
    output logic [7:0]            o_blue,
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    localparam int         VID_AW   = $clog2(VIDEO_DEPTH);
    localparam int         PAL_SIZE = PALETTE_BANKS * 256;
    localparam int         PAL_AW   = $clog2(PAL_SIZE);
    localparam logic [2:0] BANKS_W  = 3'(PALETTE_BANKS);

    // Bank numbers run 0..3; fold them into the banks that exist.
    // For two or more banks one compare/subtract is enough.
    function automatic logic [1:0] bank_wrap(input logic [1:0] b);
        logic [1:0] r;
        if (PALETTE_BANKS == 1) begin
            r = 2'd0;
        end else if ({1'b0, b} >= BANKS_W) begin
            r = 2'(b - BANKS_W[1:0]);
        end else begin
            r = b;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    logic [7:0] w_mask;

    bvmc_apb_regs u_regs (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_write_mask (w_mask)
    );

    // ------------------------------------------------------------------
    // Accept stage: latches and bank update here so the next transaction
    // already sees them; video read and palette write are issued here.
    // ------------------------------------------------------------------
    logic       r_run;
    logic [7:0] r_latch_hi;
    logic [7:0] r_latch_lo;
    logic [1:0] r_bank;

    logic        w_accept;
    t_func       w_func;
    logic [15:0] w_vaddr;
    logic [9:0]  w_pal_widx;
    logic        w_pal_we;

    assign busy     = !r_run;
    assign w_accept = start && !busy;
    assign w_func   = t_func'(i_func);

    always_comb begin
        case (w_func)
            FN_DIRECT_RD, FN_DIRECT_WR: w_vaddr = {r_latch_hi[7], i_offset[14:0]};
            FN_LATCH_RD, FN_LATCH_WR:   w_vaddr = {r_latch_hi, r_latch_lo};
            default:                    w_vaddr = i_offset;
        endcase
    end

    assign w_pal_widx = {bank_wrap(i_offset[9:8]), i_offset[7:0]};
    assign w_pal_we   = w_accept && (w_func == FN_PAL_WR);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run      <= 1'b0;
            r_latch_hi <= 8'd0;
            r_latch_lo <= 8'd0;
            r_bank     <= 2'd0;
        end else begin
            r_run <= 1'b1;
            if (w_accept) begin
                case (w_func)
                    FN_LATCH_HI: r_latch_hi <= i_data;
                    FN_LATCH_LO: r_latch_lo <= i_data;
                    FN_BANK:     r_bank     <= i_data[1:0];
                    default:     ;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: video byte is back; merge and write for bus writes,
    // forward the previous write on an address match.
    // ------------------------------------------------------------------
    logic              r_s1_valid;
    t_func             r_s1_func;
    logic [VID_AW-1:0] r_s1_addr;
    logic [7:0]        r_s1_data;
    logic [1:0]        r_s1_bank;

    logic              r_wb_valid;
    logic [VID_AW-1:0] r_wb_addr;
    logic [7:0]        r_wb_data;

    logic [7:0] w_vrd;
    logic [7:0] w_vbyte;
    logic [7:0] w_merged;
    logic       w_vid_we;
    logic [9:0] w_pen;
    logic [7:0] w_prd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_func <= w_func;
        r_s1_addr <= w_vaddr[VID_AW-1:0];
        r_s1_data <= i_data;
        r_s1_bank <= bank_wrap(r_bank);
    end

    assign w_vbyte  = (r_wb_valid && (r_wb_addr == r_s1_addr)) ? r_wb_data : w_vrd;
    assign w_merged = (w_vbyte & ~w_mask) | (r_s1_data & w_mask);
    assign w_vid_we = r_s1_valid &&
                      ((r_s1_func == FN_DIRECT_WR) || (r_s1_func == FN_LATCH_WR));
    assign w_pen    = {r_s1_bank, w_vbyte};

    bvmc_ram #(
        .DEPTH (VIDEO_DEPTH)
    ) u_video (
        .i_clk   (i_clk),
        .i_we    (w_vid_we),
        .i_waddr (r_s1_addr),
        .i_wdata (w_merged),
        .i_raddr (w_vaddr[VID_AW-1:0]),
        .o_rdata (w_vrd)
    );

    // The write landing this edge is invisible to the read issued this edge.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wb_valid <= 1'b0;
        end else begin
            r_wb_valid <= w_vid_we;
        end
    end

    always_ff @(posedge i_clk) begin
        r_wb_addr <= r_s1_addr;
        r_wb_data <= w_merged;
    end

    // Palette: written at accept, read for the pen in stage 1. A later
    // palette write to the same entry cannot overtake an earlier fetch.
    bvmc_ram #(
        .DEPTH (PAL_SIZE)
    ) u_palette (
        .i_clk   (i_clk),
        .i_we    (w_pal_we),
        .i_waddr (w_pal_widx[PAL_AW-1:0]),
        .i_wdata (i_data),
        .i_raddr (w_pen[PAL_AW-1:0]),
        .o_rdata (w_prd)
    );

    // ------------------------------------------------------------------
    // Stage 2: palette byte is back; build the result
    // ------------------------------------------------------------------
    logic       r_s2_valid;
    t_func      r_s2_func;
    logic [7:0] r_s2_byte;
    logic [9:0] r_s2_pen;
    logic [7:0] r_s2_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_func <= r_s1_func;
        r_s2_byte <= w_vbyte;
        r_s2_pen  <= w_pen;
        r_s2_data <= r_s1_data;
    end

    logic       r_valid;
    logic [7:0] r_read_data;
    logic [9:0] r_pen_index;
    t_rgb       r_rgb;

    logic [7:0] n_read_data;
    logic [9:0] n_pen_index;
    t_rgb       n_rgb;

    always_comb begin
        n_read_data = 8'd0;
        n_pen_index = 10'd0;
        n_rgb       = '0;
        case (r_s2_func)
            FN_DIRECT_RD, FN_LATCH_RD: n_read_data = r_s2_byte;
            FN_PAL_WR:                 n_rgb       = expand_color(r_s2_data);
            FN_PIXEL: begin
                n_pen_index = r_s2_pen;
                n_rgb       = expand_color(w_prd);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_read_data <= n_read_data;
        r_pen_index <= n_pen_index;
        r_rgb       <= n_rgb;
    end

    assign o_valid     = r_valid;
    assign o_read_data = r_read_data;
    assign o_pen_index = r_pen_index;
    assign o_red       = r_rgb.red;
    assign o_green     = r_rgb.green;
    assign o_blue      = r_rgb.blue;

endmodule

// File: rtl/bvmc_ram.sv
module bvmc_ram #(
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [7:0]               i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [7:0]               o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read-before-write on a same-address collision
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/bvmc_apb_regs.sv
module bvmc_apb_regs
    import bvmc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    output logic [7:0]            o_write_mask
);

    logic [7:0] r_write_mask;
    logic       w_sel_mask;

    assign w_sel_mask = (paddr[CFG_ADDR_W-1:2] == REG_WRITE_MASK);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_write_mask <= MASK_RESET;
        end else if (psel && penable && pwrite && w_sel_mask) begin
            r_write_mask <= pwdata[7:0];
        end
    end

    assign prdata       = w_sel_mask ? {24'd0, r_write_mask} : 32'd0;
    assign pready       = 1'b1;
    assign o_write_mask = r_write_mask;

endmodule

// File: rtl/bvmc_checker.sv
module bvmc_checker
    import bvmc_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic [3:0] i_func,
    input logic       o_valid,
    input logic [7:0] o_read_data,
    input logic [9:0] o_pen_index,
    input logic [7:0] o_red,
    input logic [7:0] o_green,
    input logic [7:0] o_blue
);

    // every accepted transaction yields its result with o_valid
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##3 o_valid)
        else $error("result missing three cycles after accept");

    // no result without a transaction behind it
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, 3))
        else $error("result without matching transaction");

    // a bank write reports nothing
    a_bank_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_func == FN_BANK)) |-> ##3
        (o_read_data == 8'd0 && o_pen_index == 10'd0 &&
         o_red == 8'd0 && o_green == 8'd0 && o_blue == 8'd0))
        else $error("bank write result not zero");

    // reset empties the pipe and holds off commands
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> (busy && !o_valid))
        else $error("pipe not idle after reset");

endmodule

bind bitmap_video_memory_controller bvmc_checker u_bvmc_checker (.*);
